// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define AST_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define AST_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/ffba_pkg.sv -----
// Package: types, codes and constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam logic [25:0] HEAP_MAX = 26'd33554432;
  localparam logic [25:0] HEAP_MIN = 26'd64;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] req_size;
    logic [24:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [24:0] payload_addr;
  } res_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_INIT, OP_TAKE, OP_SPLIT, OP_CLR, OP_MERGE
  } op_t;

  typedef struct packed {
    logic        valid;
    logic        used;
    logic [24:0] start;
    logic [25:0] bytes;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [25:0] n;
    logic [25:0] heap;
    logic [32:0] need;
    logic [24:0] addr;
  } cmd_t;

  typedef struct packed {
    logic        fit;
    logic        addr_eq;
    logic        used;
    logic        left_free;
    logic        right_free;
    logic [24:0] start;
    logic [25:0] bytes;
  } info_t;
endpackage

// ----- rtl/ffba_cell.sv -----
// One table entry of the allocator chain, shifting to and from its neighbors.
`timescale 1ns / 1ps
module ffba_cell #(
  parameter int IDX = 0,
  parameter int IW = 6,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ffba_pkg::cmd_t   cmd,
  input  logic [IW-1:0]    idx,
  input  ffba_pkg::entry_t left,
  input  ffba_pkg::entry_t right,
  output ffba_pkg::entry_t ent,
  output ffba_pkg::info_t  info
);
  localparam logic [IW:0] ME = (IW + 1)'(IDX);
  localparam logic [25:0] HB = 26'(HEADER_BYTES);

  logic [IW:0] at, at1;
  ffba_pkg::entry_t ent_next;

  assign at = {1'b0, idx};
  assign at1 = at + 1'b1;

  always_comb begin
    ent_next = ent;
    case (cmd.op)
      ffba_pkg::OP_INIT: begin
        ent_next.valid = (IDX == 0);
        ent_next.used = 1'b0;
        ent_next.start = '0;
        ent_next.bytes = (IDX == 0) ? cmd.heap : '0;
      end
      ffba_pkg::OP_TAKE: if (ME == at) ent_next.used = 1'b1;
      ffba_pkg::OP_CLR: if (ME == at) ent_next.used = 1'b0;
      ffba_pkg::OP_SPLIT: begin
        if (ME == at) begin
          ent_next.bytes = cmd.n;
          ent_next.used = 1'b1;
        end else if (ME == at1) begin
          ent_next.valid = 1'b1;
          ent_next.used = 1'b0;
          ent_next.start = left.start + cmd.n[24:0];
          ent_next.bytes = left.bytes - cmd.n;
        end else if (ME > at1) begin
          ent_next = left;
        end
      end
      ffba_pkg::OP_MERGE: begin
        if (ME == at) begin
          ent_next.bytes = ent.bytes + right.bytes;
          ent_next.used = 1'b0;
        end else if (ME > at) begin
          ent_next = right;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= (IDX == 0);
      ent.used <= 1'b0;
      ent.start <= '0;
      ent.bytes <= (IDX == 0) ? ffba_pkg::HEAP_MAX : '0;
    end else begin
      ent <= ent_next;
    end
  end

  always_comb begin
    info = '0;
    if (ME == at) begin
      info.fit = ent.valid && !ent.used && ({7'b0, ent.bytes} > cmd.need);
      info.addr_eq = ent.valid && (({1'b0, ent.start} + HB) == {1'b0, cmd.addr});
      info.used = ent.used;
      info.left_free = left.valid && !left.used;
      info.right_free = right.valid && !right.used;
      info.start = ent.start;
      info.bytes = ent.bytes;
    end
  end
endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// Top level: first-fit heap block allocator built as a chain of entry cells.
`timescale 1ns / 1ps
// Usage:
//  A request (allocate or free) is taken when start is high and busy is low.
//  Its result appears on result, marked by done for exactly one cycle; the
//  receiver cannot stall, so results are never held back.
//  A zero-size allocate gives its result in the cycle after the request.
//  Otherwise the controller visits one table entry per cycle: an allocate
//  ends at the first fitting entry or after all blocks; a free scans to its
//  entry, then goes through S_FREE_L and S_FREE_R, which do the coalescing.
//  Throughput: one request at a time; the next one is taken once busy is low.
//  Configuration: cfg_data (heap size) is written when cfg_valid and cfg_ready
//  are high; cfg_ready is high while idle. A write saturates the size to
//  64..33554432 and rebuilds the table as one free block, seen in the cycle after.
//  Reset: synchronous rst gives one free block of 33554432 bytes at offset 0.
//  Splits and merges shift all cells beyond the split or merge point by one neighbor together.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffba_pkg::req_t request,
  output logic           done,
  output ffba_pkg::res_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [25:0]    cfg_data
);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [32:0] H33 = 33'(HEADER_BYTES);
  localparam logic [25:0] H26 = 26'(HEADER_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FREE_L, S_FREE_R} state_t;

  state_t state;
  logic [CW-1:0] k, count;
  logic act;
  logic [31:0] req;
  logic [24:0] faddr;
  logic lf, rf;

  ffba_pkg::cmd_t cmd;
  logic [IW-1:0] cidx;
  ffba_pkg::entry_t ents [MAX_BLOCKS];
  ffba_pkg::info_t infos [MAX_BLOCKS];
  ffba_pkg::info_t hit;
  logic [32:0] need;
  logic [33:0] whole_max;
  logic [25:0] heap_sat;
  logic accept;

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept = start && !busy;
  assign need = {1'b0, req} + H33;
  assign whole_max = {2'b0, req} + {1'b0, H33} + {1'b0, H33};

  always_comb begin
    heap_sat = cfg_data;
    if (cfg_data < ffba_pkg::HEAP_MIN) heap_sat = ffba_pkg::HEAP_MIN;
    if (cfg_data > ffba_pkg::HEAP_MAX) heap_sat = ffba_pkg::HEAP_MAX;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffba_pkg::entry_t lin, rin;
      if (g == 0) begin : g_l0
        assign lin = '0;
      end else begin : g_l
        assign lin = ents[g-1];
      end
      if (g == MAX_BLOCKS - 1) begin : g_rn
        assign rin = '0;
      end else begin : g_r
        assign rin = ents[g+1];
      end
      ffba_cell #(.IDX(g), .IW(IW), .HEADER_BYTES(HEADER_BYTES)) u_cell (
        .clk(clk), .rst(rst), .cmd(cmd), .idx(cidx),
        .left(lin), .right(rin), .ent(ents[g]), .info(infos[g])
      );
    end
  endgenerate

  always_comb begin
    hit = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) hit = hit | infos[i];
  end

  // command to the cells, decoded from the controller state
  always_comb begin
    cmd.op = ffba_pkg::OP_NOP;
    cmd.n = need[25:0];
    cmd.heap = heap_sat;
    cmd.need = need;
    cmd.addr = faddr;
    cidx = k[IW-1:0];
    unique case (state)
      S_IDLE: if (cfg_valid) cmd.op = ffba_pkg::OP_INIT;
      S_SCAN: begin
        if (k != count) begin
          if (act == ffba_pkg::ACT_ALLOC) begin
            if (hit.fit) begin
              if (({8'b0, hit.bytes} > whole_max) && (count < MAXC))
                cmd.op = ffba_pkg::OP_SPLIT;
              else
                cmd.op = ffba_pkg::OP_TAKE;
            end
          end else if (hit.addr_eq && hit.used) begin
            cmd.op = ffba_pkg::OP_CLR;
          end
        end
      end
      S_FREE_L: begin
        cidx = IW'(k - 1'b1);
        if (lf) cmd.op = ffba_pkg::OP_MERGE;
      end
      S_FREE_R: if (rf) cmd.op = ffba_pkg::OP_MERGE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      count <= CW'(1);
      k <= '0;
      lf <= 1'b0;
      rf <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) count <= CW'(1);
          if (accept) begin
            act <= request.action;
            req <= request.req_size;
            faddr <= request.free_addr;
            k <= '0;
            if (request.action == ffba_pkg::ACT_ALLOC && request.req_size == '0) begin
              done <= 1'b1;
              result <= {ffba_pkg::ST_ZERO, 25'd0};
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (k == count) begin
            done <= 1'b1;
            result.payload_addr <= '0;
            result.status <= (act == ffba_pkg::ACT_ALLOC) ? ffba_pkg::ST_NOFIT
                                                          : ffba_pkg::ST_BADFREE;
            state <= S_IDLE;
          end else if (act == ffba_pkg::ACT_ALLOC) begin
            if (hit.fit) begin
              if (cmd.op == ffba_pkg::OP_SPLIT) count <= count + 1'b1;
              done <= 1'b1;
              result.status <= ffba_pkg::ST_OK;
              result.payload_addr <= 25'({1'b0, hit.start} + H26);
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end else if (hit.addr_eq) begin
            if (!hit.used) begin
              done <= 1'b1;
              result <= {ffba_pkg::ST_BADFREE, 25'd0};
              state <= S_IDLE;
            end else begin
              lf <= hit.left_free;
              rf <= hit.right_free;
              state <= S_FREE_L;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FREE_L: begin
          if (lf) begin
            k <= k - 1'b1;
            count <= count - 1'b1;
          end
          state <= S_FREE_R;
        end
        S_FREE_R: begin
          if (rf) count <= count - 1'b1;
          done <= 1'b1;
          result <= {ffba_pkg::ST_OK, 25'd0};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/ffba_checker.sv -----
// Port-level checker for the first-fit block allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffba_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input ffba_pkg::res_t result,
  input logic           cfg_ready
);
  `AST_IMP(a_addr_zero, clk, rst, done && result.status != ffba_pkg::ST_OK, result.payload_addr == '0, "address not zero on failed request")
  `AST_NXT(a_accept_progress, clk, rst, start && !busy, busy || done, "accepted request neither busy nor done")
  `AST_IMP(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `AST_IMP(a_cfg_idle, clk, rst, cfg_ready, !busy, "config ready while busy")
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ----- tb/first_fit_block_allocator_tb.sv -----
// Testbench for the first-fit block allocator: directed and random requests checked against a table model.
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;

  localparam int NBLK = 64;
  localparam int HDR = 24;

  class heap_scoreboard;
    logic [25:0] heap;
    logic [24:0] bstart[NBLK];
    logic [25:0] bbytes[NBLK];
    bit bused[NBLK];
    int bcount;
    ffba_pkg::res_t pending[$];
    int errors;

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void rebuild(logic [25:0] v);
      if (v < ffba_pkg::HEAP_MIN) v = ffba_pkg::HEAP_MIN;
      if (v > ffba_pkg::HEAP_MAX) v = ffba_pkg::HEAP_MAX;
      heap = v;
      for (int j = 0; j < NBLK; j++) begin
        bstart[j] = '0;
        bbytes[j] = '0;
        bused[j] = 0;
      end
      bbytes[0] = heap;
      bcount = 1;
    endfunction

    function void drop(int k);
      for (int j = k; j + 1 < bcount; j++) begin
        bstart[j] = bstart[j+1];
        bbytes[j] = bbytes[j+1];
        bused[j] = bused[j+1];
      end
      bcount--;
      bstart[bcount] = '0;
      bbytes[bcount] = '0;
      bused[bcount] = 0;
    endfunction

    function ffba_pkg::res_t alloc_block(logic [31:0] sz);
      ffba_pkg::res_t r;
      longint need, whole_max, b;
      r.status = ffba_pkg::ST_NOFIT;
      r.payload_addr = '0;
      need = longint'(sz) + HDR;
      whole_max = longint'(sz) + 2 * HDR;
      if (sz == 0) begin
        r.status = ffba_pkg::ST_ZERO;
        return r;
      end
      for (int i = 0; i < bcount; i++) begin
        b = bbytes[i];
        if (bused[i] || b <= need) continue;
        if (b > whole_max && bcount < NBLK) begin
          for (int j = bcount; j > i + 1; j--) begin
            bstart[j] = bstart[j-1];
            bbytes[j] = bbytes[j-1];
            bused[j] = bused[j-1];
          end
          bstart[i+1] = bstart[i] + 25'(need);
          bbytes[i+1] = 26'(b - need);
          bused[i+1] = 0;
          bcount++;
          bbytes[i] = 26'(need);
        end
        bused[i] = 1;
        r.status = ffba_pkg::ST_OK;
        r.payload_addr = bstart[i] + 25'(HDR);
        return r;
      end
      return r;
    endfunction

    function ffba_pkg::res_t free_block(logic [24:0] a);
      ffba_pkg::res_t r;
      int i;
      r.status = ffba_pkg::ST_BADFREE;
      r.payload_addr = '0;
      for (i = 0; i < bcount; i++)
        if (longint'(bstart[i]) + HDR == longint'(a)) break;
      if (i >= bcount || !bused[i]) return r;
      bused[i] = 0;
      if (i > 0 && !bused[i-1]) begin
        bbytes[i-1] += bbytes[i];
        drop(i);
        i--;
      end
      if (i + 1 < bcount && !bused[i+1]) begin
        bbytes[i] += bbytes[i+1];
        drop(i + 1);
      end
      r.status = ffba_pkg::ST_OK;
      return r;
    endfunction

    function void note_request(ffba_pkg::req_t q);
      if (q.action == ffba_pkg::ACT_ALLOC) pending.push_back(alloc_block(q.req_size));
      else pending.push_back(free_block(q.free_addr));
    endfunction

    task check_result(ffba_pkg::res_t got);
      ffba_pkg::res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.payload_addr !== want.payload_addr)
        report_mismatch($sformatf("payload_addr %0h, expected %0h",
                                  got.payload_addr, want.payload_addr));
    endtask

    function int used_addr();
      int k, n;
      n = 0;
      for (int i = 0; i < bcount; i++) if (bused[i]) n++;
      if (n == 0) return -1;
      k = $urandom_range(n - 1);
      for (int i = 0; i < bcount; i++)
        if (bused[i]) begin
          if (k == 0) return int'(bstart[i]) + HDR;
          k--;
        end
      return -1;
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic busy, done, cfg_ready;
  logic [25:0] cfg_data = '0;
  ffba_pkg::req_t request = '0;
  ffba_pkg::res_t result;
  heap_scoreboard sb;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic send_request(logic act, logic [31:0] sz, logic [24:0] a);
    ffba_pkg::req_t q;
    q.action = act;
    q.req_size = sz;
    q.free_addr = a;
    @(posedge clk);
    start <= 1;
    request <= q;
    do @(posedge clk); while (busy);
    sb.note_request(q);
    start <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NBLK + 8) @(posedge clk);
  endtask

  task automatic write_heap(logic [25:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.rebuild(v);
    cfg_valid <= 0;
  endtask

  task automatic random_request(int maxsz);
    int a;
    int r;
    r = $urandom_range(99);
    if (r < 45) send_request(ffba_pkg::ACT_ALLOC, 32'($urandom_range(maxsz)), '0);
    else if (r < 85) begin
      a = sb.used_addr();
      if (a < 0) send_request(ffba_pkg::ACT_ALLOC, 32'($urandom_range(maxsz, 1)), '0);
      else send_request(ffba_pkg::ACT_FREE, $urandom, 25'(a));
    end else if (r < 92) send_request(ffba_pkg::ACT_FREE, $urandom, 25'($urandom));
    else send_request(ffba_pkg::ACT_ALLOC, $urandom, 25'($urandom));
  endtask

  initial begin
    int burst;
    int sizes[4] = '{64, 100000, 33554432, 1000};
    sb = new();
    sb.rebuild(ffba_pkg::HEAP_MAX);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_request(ffba_pkg::ACT_ALLOC, 32'd0, '1);
    send_request(ffba_pkg::ACT_ALLOC, 32'hFFFFFFFF, '0);
    send_request(ffba_pkg::ACT_ALLOC, 32'd1, '0);
    send_request(ffba_pkg::ACT_ALLOC, 32'd100, '1);
    send_request(ffba_pkg::ACT_ALLOC, 32'd33554000, '0);
    send_request(ffba_pkg::ACT_FREE, '1, 25'd24);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd24);
    send_request(ffba_pkg::ACT_FREE, '0, '1);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd0);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd49);
    write_heap(26'd0);
    send_request(ffba_pkg::ACT_ALLOC, 32'd16, '0);
    send_request(ffba_pkg::ACT_ALLOC, 32'd15, '0);
    send_request(ffba_pkg::ACT_ALLOC, 32'd1, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd24);
    write_heap(26'h3FFFFFF);
    for (int i = 0; i < 70; i++) send_request(ffba_pkg::ACT_ALLOC, 32'd30, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd78);
    send_request(ffba_pkg::ACT_FREE, '0, 25'd24);
    // random phases
    for (int p = 0; p < 4; p++) begin
      write_heap(26'(sizes[p]));
      for (int n = 0; n < 80; ) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst && n < 80; b++, n++)
          random_request(p == 0 ? 60 : (p == 3 ? 80 : 3000));
        if (n == 40) drain();
        else repeat ($urandom_range(6)) @(posedge clk);
      end
    end
    drain();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
